FILE: sv/dq_pkg.sv
// Shared types and codes for the double-ended queue.
package dq_pkg;

   localparam int WORD_W  = 32;
   localparam int CMD_W   = 3;
   localparam int COUNT_W = 5;

   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;
   localparam logic [CMD_W-1:0] CMD_NOP        = 3'd5;

   // Controller to datapath commands.
   typedef struct packed {
      logic take;   // request accepted this cycle: update pointers, write slot
      logic fetch;  // read front and rear slots into the result registers
   } dq_cmd_type;

endpackage

FILE: sv/dq_ctrl.sv
// Sequencer for the double-ended queue: accept, fetch, send.
module dq_ctrl
   import dq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output dq_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_SEND  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_SEND);
   assign cmd.take   = req_tvalid && req_tready;
   assign cmd.fetch  = (state_ff == ST_FETCH);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sv/dq_datapath.sv
// Ring store, head and tail pointers, fill count and result registers.
module dq_datapath
   import dq_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic               clock,
   input  logic               reset,
   input  dq_cmd_type         cmd,
   input  logic [CMD_W-1:0]   command,
   input  logic [WORD_W-1:0]  data_value,
   output logic [WORD_W-1:0]  front_value,
   output logic [WORD_W-1:0]  rear_value,
   output logic [COUNT_W-1:0] entry_count,
   output logic               is_empty,
   output logic               op_error
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WORD_W-1:0] slot_mem [DEPTH];

   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              err_ff, err_in;
   logic [WORD_W-1:0] front_ff;
   logic [WORD_W-1:0] rear_ff;

   logic              wr_en;
   logic [PTR_W-1:0]  wr_addr;
   logic              full;
   logic              empty;

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] wrap_dec(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
   endfunction

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      err_in   = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = tail_ff;
      unique case (command)
         CMD_PUSH_FRONT: begin
            if (full) begin
               err_in = 1'b1;
            end else begin
               head_in  = wrap_dec(head_ff);
               wr_en    = 1'b1;
               wr_addr  = wrap_dec(head_ff);
               count_in = count_ff + CNT_W'(1);
            end
         end
         CMD_PUSH_REAR: begin
            if (full) begin
               err_in = 1'b1;
            end else begin
               tail_in  = wrap_inc(tail_ff);
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         CMD_POP_FRONT: begin
            if (empty) begin
               err_in = 1'b1;
            end else begin
               head_in  = wrap_inc(head_ff);
               count_in = count_ff - CNT_W'(1);
            end
         end
         CMD_POP_REAR: begin
            if (empty) begin
               err_in = 1'b1;
            end else begin
               tail_in  = wrap_dec(tail_ff);
               count_in = count_ff - CNT_W'(1);
            end
         end
         CMD_CLEAR: begin
            head_in  = '0;
            tail_in  = '0;
            count_in = '0;
         end
         default: begin
            // nop and unused codes leave the state alone
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.take) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) err_ff <= err_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.take && wr_en) slot_mem[wr_addr] <= data_value;
   end

   // Read both ends from the store once the update has landed.
   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         front_ff <= slot_mem[head_ff];
         rear_ff  <= slot_mem[wrap_dec(tail_ff)];
      end
   end

   assign is_empty    = empty;
   assign front_value = empty ? '1 : front_ff;
   assign rear_value  = empty ? '1 : rear_ff;
   assign entry_count = COUNT_W'(count_ff);
   assign op_error    = err_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count above depth");

   a_ring_consistent: assert property (@(posedge clock) disable iff (reset)
      tail_ff == ((({1'b0, head_ff} + (PTR_W+1)'(count_ff)) >= (PTR_W+1)'(DEPTH)) ?
                  PTR_W'({1'b0, head_ff} + (PTR_W+1)'(count_ff) - (PTR_W+1)'(DEPTH)) :
                  PTR_W'({1'b0, head_ff} + (PTR_W+1)'(count_ff))))
      else $error("tail does not match head plus count");

   a_refused_holds: assert property (@(posedge clock) disable iff (reset)
      (cmd.take && err_in) |=> ($stable(count_ff) && $stable(head_ff) && $stable(tail_ff)))
      else $error("refused request changed the queue");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (cmd.take && command == CMD_CLEAR) |=> (count_ff == '0 && !err_ff))
      else $error("clear did not empty the queue");
`endif

endmodule

FILE: sv/double_ended_queue.sv
// Double-ended queue of 32-bit words in a ring store of DEPTH slots.
//
// Request channel (req_): tuser carries the command (push front, push rear,
// pop front, pop rear, clear, nop; unused codes act as nop), tdata the word
// to push. Every request yields exactly one response on the rsp_ channel.
// The response carries the front word, the rear word (both all ones when
// the queue is empty), the fill count in tdata, and the empty and error
// flags in tuser. A pop on an empty queue or a push on a full one is refused:
// the queue is unchanged and the error flag is set.
//
// Timing: the accept cycle updates the pointers and writes the slot, the next
// cycle reads the front and rear slots from the store's two read ports, and
// the response is then presented from those registers; the store is read only
// after the write has landed. Only one request is in flight: req_tready is
// low until the response is taken, and a stalled response holds its value.
// Reset empties the queue; slot contents are not cleared and are never
// visible, since only occupied slots are reported.
module double_ended_queue
   import dq_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] data_value
   input  logic [2:0]  req_tuser,   // [2:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [31:0] front_value, [63:32] rear_value,
                                    // [68:64] entry_count, [71:69] zero
   output logic [1:0]  rsp_tuser    // [0] is_empty, [1] op_error
);

   dq_cmd_type         cmd;
   logic [WORD_W-1:0]  front_value;
   logic [WORD_W-1:0]  rear_value;
   logic [COUNT_W-1:0] entry_count;
   logic               is_empty;
   logic               op_error;

   dq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   dq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .command     (req_tuser),
      .data_value  (req_tdata),
      .front_value (front_value),
      .rear_value  (rear_value),
      .entry_count (entry_count),
      .is_empty    (is_empty),
      .op_error    (op_error)
   );

   assign rsp_tdata = {3'b000, entry_count, rear_value, front_value};
   assign rsp_tuser = {op_error, is_empty};

endmodule
